@@ sv/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assertion macros
// concurrent checks on a clock with an active-low reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// antecedent implies consequent in the same cycle
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// expression holds in every cycle out of reset
`define ASSERT_ALWAYS(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error(msg);

`else

`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`define ASSERT_ALWAYS(label, clk, rst_n, expr, msg)

`endif

`endif

@@ sv/mpss_pkg.sv @@
// ----------------------------------------------------------------------------
// mixture position score sum package
// shared types, field widths and defaults
// ----------------------------------------------------------------------------
`default_nettype none

package mpss_pkg;

    localparam int NUM_CLUSTERS_DEF  = 16;
    localparam int SEQ_POSITIONS_DEF = 256;
    localparam int ALPHABET_SIZE_DEF = 21;

    localparam int CLUSTER_W  = 6;
    localparam int RESIDUE_W  = 5;
    localparam int POSITION_W = 10;
    localparam int ENTRY_W    = 24;
    localparam int SCORE_W    = 32;

    localparam logic [RESIDUE_W-1:0] MASK_THRESHOLD_RESET = 5'd20;

    localparam logic [SCORE_W-1:0] SCORE_MAX = 32'h7fff_ffff;
    localparam logic [SCORE_W-1:0] SCORE_MIN = 32'h8000_0000;

    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_SCORE = 1'b1;

    typedef enum logic [0:0] {
        CFG_MASKED_MODE    = 1'b0,
        CFG_MASK_THRESHOLD = 1'b1
    } cfg_reg_e;

    typedef struct packed {
        logic                        command;
        logic [RESIDUE_W-1:0]        residue;
        logic                        seq_last;
        logic [CLUSTER_W-1:0]        load_cluster;
        logic [POSITION_W-1:0]       load_position;
        logic signed [ENTRY_W-1:0]   load_value;
    } item_t;

    typedef struct packed {
        logic [CLUSTER_W-1:0]        cluster_index;
        logic signed [SCORE_W-1:0]   score;
        logic                        run_last;
        logic                        range_flag;
    } result_t;

    // stage-two controls shared by all cluster lanes
    typedef struct packed {
        logic add;
        logic last;
    } lane_ctrl_t;

endpackage

`default_nettype wire

@@ sv/mixture_position_score_sum.sv @@
// output: a residue marked last passes stage one, stage two and the result buffer
//   registers, then gives NUM_CLUSTERS results, one per cycle while not stalled
// throughput: one item per cycle; a last residue waits until the previous run's
//   results have left the single result buffer (NUM_CLUSTERS output transfers)
// reset: sums, position, range flag and registers cleared to defaults; table
//   contents undefined until loaded, no clearing pass
// ----------------------------------------------------------------------------
// mixture position score sum
// per-cluster position-specific table sums with banked tables and a result buffer
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module mixture_position_score_sum #(
    parameter int NUM_CLUSTERS  = mpss_pkg::NUM_CLUSTERS_DEF,
    parameter int SEQ_POSITIONS = mpss_pkg::SEQ_POSITIONS_DEF,
    parameter int ALPHABET_SIZE = mpss_pkg::ALPHABET_SIZE_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            item_valid,
    output logic                                 item_stall,
    input  wire mpss_pkg::item_t                 item,
    output logic                                 result_valid,
    input  wire logic                            result_stall,
    output mpss_pkg::result_t                    result,
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire mpss_pkg::cfg_reg_e              cfg_index,
    input  wire logic [mpss_pkg::RESIDUE_W-1:0]  cfg_data
);

    import mpss_pkg::*;

    localparam int DEPTH  = SEQ_POSITIONS * ALPHABET_SIZE;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int POS_W  = (SEQ_POSITIONS > 1) ? $clog2(SEQ_POSITIONS) : 1;
    localparam int PC_W   = $clog2(SEQ_POSITIONS + 1);
    localparam int CNT_W  = (NUM_CLUSTERS > 1) ? $clog2(NUM_CLUSTERS) : 1;

    // configuration
    logic                 masked_mode_reg;
    logic [RESIDUE_W-1:0] mask_threshold_reg;

    // stage one
    logic                 s1_valid_reg;
    item_t                s1_item_reg;
    logic [PC_W-1:0]      pos_reg;
    logic [PC_W-1:0]      pos_next;
    logic                 err_reg;
    logic                 err_next;

    // stage two
    logic                 s2_add_reg;
    logic                 s2_last_reg;
    logic                 s2_flag_reg;
    lane_ctrl_t           lane_ctrl;

    // result buffer
    logic                 busy_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic                 flag_reg;
    logic [SCORE_W-1:0]   snap_reg [NUM_CLUSTERS];
    logic [SCORE_W-1:0]   lane_total [NUM_CLUSTERS];

    logic                 item_xfer;
    logic                 result_xfer;
    logic                 last_pending;
    logic                 s1_load;
    logic                 s1_score;
    logic                 load_ok;
    logic                 masked;
    logic                 out_of_range;
    logic                 add_en;
    logic                 err_now;
    logic [POS_W-1:0]     pos_idx;
    logic [ADDR_W-1:0]    addr;
    logic                 cnt_at_end;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            masked_mode_reg    <= 1'b0;
            mask_threshold_reg <= MASK_THRESHOLD_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_MASKED_MODE:    masked_mode_reg    <= cfg_data[0];
                CFG_MASK_THRESHOLD: mask_threshold_reg <= cfg_data;
            endcase
        end
    end

    // hold off a second run end until the buffer is free for it
    assign last_pending = busy_reg || s2_last_reg
                       || (s1_valid_reg && s1_score && s1_item_reg.seq_last);
    assign item_stall   = last_pending && (item.command == CMD_SCORE) && item.seq_last;
    assign item_xfer    = item_valid && !item_stall;
    assign result_xfer  = result_valid && !result_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= item_xfer;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_xfer)
        begin
            s1_item_reg <= item;
        end
    end

    always_comb
    begin
        s1_load  = s1_valid_reg && (s1_item_reg.command == CMD_LOAD);
        s1_score = s1_valid_reg && (s1_item_reg.command == CMD_SCORE);
        load_ok  = ({1'b0, s1_item_reg.load_cluster} < (CLUSTER_W + 1)'(NUM_CLUSTERS))
                && ({1'b0, s1_item_reg.load_position} < (POSITION_W + 1)'(SEQ_POSITIONS))
                && ({1'b0, s1_item_reg.residue} < (RESIDUE_W + 1)'(ALPHABET_SIZE));

        masked       = masked_mode_reg && (s1_item_reg.residue > mask_threshold_reg);
        out_of_range = ({1'b0, s1_item_reg.residue} >= (RESIDUE_W + 1)'(ALPHABET_SIZE))
                    || (pos_reg == PC_W'(SEQ_POSITIONS));
        add_en       = !masked && !out_of_range;
        err_now      = !masked && out_of_range;

        pos_idx = (s1_item_reg.command == CMD_LOAD) ? s1_item_reg.load_position[POS_W-1:0]
                                                    : pos_reg[POS_W-1:0];
        addr    = ADDR_W'(pos_idx) * ADDR_W'(ALPHABET_SIZE) + ADDR_W'(s1_item_reg.residue);

        pos_next = pos_reg;
        err_next = err_reg;
        if (s1_score)
        begin
            if (s1_item_reg.seq_last)
            begin
                pos_next = '0;
                err_next = 1'b0;
            end
            else
            begin
                err_next = err_reg || err_now;
                if (pos_reg != PC_W'(SEQ_POSITIONS))
                begin
                    pos_next = pos_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg     <= '0;
            err_reg     <= 1'b0;
            s2_add_reg  <= 1'b0;
            s2_last_reg <= 1'b0;
        end
        else
        begin
            pos_reg     <= pos_next;
            err_reg     <= err_next;
            s2_add_reg  <= s1_score && add_en;
            s2_last_reg <= s1_score && s1_item_reg.seq_last;
        end
    end

    always_ff @(posedge clk)
    begin
        s2_flag_reg <= err_reg || err_now;
    end

    assign lane_ctrl.add  = s2_add_reg;
    assign lane_ctrl.last = s2_last_reg;

    for (genvar k = 0; k < NUM_CLUSTERS; k++)
    begin : g_lane
        mpss_lane #(
            .SEQ_POSITIONS (SEQ_POSITIONS),
            .ALPHABET_SIZE (ALPHABET_SIZE),
            .ADDR_W        (ADDR_W)
        ) u_lane (
            .clk     (clk),
            .rst_n   (rst_n),
            .wr_en   (s1_load && load_ok && (s1_item_reg.load_cluster == CLUSTER_W'(k))),
            .rd_en   (s1_score),
            .addr    (addr),
            .wr_data (s1_item_reg.load_value),
            .ctrl    (lane_ctrl),
            .total   (lane_total[k])
        );
    end

    assign cnt_at_end = (cnt_reg == CNT_W'(NUM_CLUSTERS - 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (s2_last_reg)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end
        else if (result_xfer)
        begin
            if (cnt_at_end)
            begin
                busy_reg <= 1'b0;
            end
            else
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
        end
    end

    // run snapshot, shifted towards the head on each transfer
    always_ff @(posedge clk)
    begin
        if (s2_last_reg)
        begin
            flag_reg <= s2_flag_reg;
            for (int i = 0; i < NUM_CLUSTERS; i++)
            begin
                snap_reg[i] <= lane_total[i];
            end
        end
        else if (result_xfer)
        begin
            for (int i = 0; i < NUM_CLUSTERS - 1; i++)
            begin
                snap_reg[i] <= snap_reg[i+1];
            end
        end
    end

    assign result_valid         = busy_reg;
    assign result.cluster_index = CLUSTER_W'(cnt_reg);
    assign result.score         = snap_reg[0];
    assign result.run_last      = cnt_at_end;
    assign result.range_flag    = flag_reg;

    `ASSERT_IMPLY(a_snap_free, clk, rst_n, s2_last_reg, !busy_reg,
        "run end reached the buffer while results were still pending")
    `ASSERT_NEXT(a_drain_done, clk, rst_n, result_xfer && cnt_at_end, !busy_reg,
        "buffer still busy after the final result transfer")
    `ASSERT_ALWAYS(a_pos_bound, clk, rst_n, pos_reg <= PC_W'(SEQ_POSITIONS),
        "position counter beyond table length")
    `ASSERT_NEXT(a_pos_clear, clk, rst_n, s1_score && s1_item_reg.seq_last,
        pos_reg == '0 && !err_reg, "position or flag not cleared at run end")

endmodule

`default_nettype wire

@@ sv/mpss_lane.sv @@
// ----------------------------------------------------------------------------
// mpss cluster lane
// one cluster's table bank with registered read and saturating accumulator
// ----------------------------------------------------------------------------
`default_nettype none

module mpss_lane #(
    parameter int SEQ_POSITIONS = mpss_pkg::SEQ_POSITIONS_DEF,
    parameter int ALPHABET_SIZE = mpss_pkg::ALPHABET_SIZE_DEF,
    parameter int ADDR_W        = $clog2(SEQ_POSITIONS * ALPHABET_SIZE)
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          wr_en,
    input  wire logic                          rd_en,
    input  wire logic [ADDR_W-1:0]             addr,
    input  wire logic [mpss_pkg::ENTRY_W-1:0]  wr_data,
    input  wire mpss_pkg::lane_ctrl_t          ctrl,
    output logic      [mpss_pkg::SCORE_W-1:0]  total
);

    import mpss_pkg::*;

    localparam int DEPTH = SEQ_POSITIONS * ALPHABET_SIZE;

    logic [ENTRY_W-1:0] bank_mem [DEPTH];
    logic [ENTRY_W-1:0] rd_data_reg;
    logic [SCORE_W-1:0] sum_reg;
    logic [SCORE_W-1:0] sum_next;
    logic [SCORE_W:0]   sum_wide;
    logic [SCORE_W-1:0] sum_sat;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            bank_mem[addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= bank_mem[addr];
        end
    end

    // 33-bit add, clamp on overflow
    always_comb
    begin
        sum_wide = {sum_reg[SCORE_W-1], sum_reg}
                 + {{(SCORE_W + 1 - ENTRY_W){rd_data_reg[ENTRY_W-1]}}, rd_data_reg};
        if (sum_wide[SCORE_W] != sum_wide[SCORE_W-1])
        begin
            sum_sat = sum_wide[SCORE_W] ? SCORE_MIN : SCORE_MAX;
        end
        else
        begin
            sum_sat = sum_wide[SCORE_W-1:0];
        end
        total    = ctrl.add ? sum_sat : sum_reg;
        sum_next = ctrl.last ? '0 : total;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg <= '0;
        end
        else
        begin
            sum_reg <= sum_next;
        end
    end

endmodule

`default_nettype wire
